### hdl/set_assoc_lru_tag_lookup_defines.svh
// ---------------------------------------------------------------------------
// Set-associative LRU tag lookup: assertion macros
// Shared property templates for the lookup's checks.
// ---------------------------------------------------------------------------
`ifndef SET_ASSOC_LRU_TAG_LOOKUP_DEFINES_SVH
`define SET_ASSOC_LRU_TAG_LOOKUP_DEFINES_SVH

// same-cycle implication
`define SLRU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SLRU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

### hdl/slru_pkg.sv
// ---------------------------------------------------------------------------
// Set-associative LRU tag lookup: package
// Shared constants, register codes and types.
// ---------------------------------------------------------------------------
package slru_pkg;

    localparam int SETS_DEFAULT      = 1024;
    localparam int WAYS_DEFAULT      = 8;
    localparam int ADDR_BITS_DEFAULT = 32;

    localparam int SET_W          = 10;
    localparam int TAG_W          = 32;
    localparam int CNT_W          = 32;
    localparam int MAX_INDEX_BITS = 10;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE = 2'd2;

    localparam logic [4:0] OFFSET_BITS_RESET = 5'd5;
    localparam logic [3:0] INDEX_BITS_RESET  = 4'd6;
    localparam logic [3:0] WAYS_IN_USE_RESET = 4'd8;

    typedef struct packed {
        logic [4:0] offset_bits;
        logic [3:0] index_bits;
        logic [3:0] ways_in_use;
    } cfg_t;

    typedef struct packed {
        logic [SET_W-1:0] set_index;
        logic [TAG_W-1:0] tag;
    } qent_t;

endpackage

### hdl/set_assoc_lru_tag_lookup.sv
// Flow: the front end queues each address's set index and tag, first reducing
// an index of SETS or more (multiply, then subtract); the back end pops items
// one at a time, reads the row from the single-port set memory, then updates and
// writes it back. A full queue or an unaccepted result (m_ready low) stalls.
// Reset: synchronous; a clearing pass over all SETS rows zeroes the valid bits,
// and no address is taken until it ends. Configuration writes are always taken.
// ---------------------------------------------------------------------------
// Set-associative LRU tag lookup: top level
// Config registers, front end, decoupling queue and back end.
// ---------------------------------------------------------------------------
module set_assoc_lru_tag_lookup import slru_pkg::*; #(
    parameter int SETS      = SETS_DEFAULT,
    parameter int WAYS      = WAYS_DEFAULT,
    parameter int ADDR_BITS = ADDR_BITS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [ADDR_BITS-1:0]  s_address,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_hit,
    output logic [SET_W-1:0]      m_set_index,
    output logic                  m_evicted,
    output logic [TAG_W-1:0]      m_evicted_tag,
    output logic [CNT_W-1:0]      m_hit_total,
    output logic [CNT_W-1:0]      m_access_total
);

    cfg_t  cfg_reg;
    logic  clearing;
    logic  q_full, q_empty, q_push, q_pop;
    qent_t q_in, q_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.offset_bits <= OFFSET_BITS_RESET;
            cfg_reg.index_bits  <= INDEX_BITS_RESET;
            cfg_reg.ways_in_use <= WAYS_IN_USE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_OFFSET_BITS: cfg_reg.offset_bits <= cfg_data;
                REG_INDEX_BITS:  cfg_reg.index_bits  <= cfg_data[3:0];
                REG_WAYS_IN_USE: cfg_reg.ways_in_use <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    slru_front #(
        .SETS      (SETS),
        .ADDR_BITS (ADDR_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .clearing  (clearing),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_address (s_address),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    slru_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    slru_back #(
        .SETS (SETS),
        .WAYS (WAYS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .clearing       (clearing),
        .q_empty        (q_empty),
        .q_data         (q_out),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hit          (m_hit),
        .m_set_index    (m_set_index),
        .m_evicted      (m_evicted),
        .m_evicted_tag  (m_evicted_tag),
        .m_hit_total    (m_hit_total),
        .m_access_total (m_access_total)
    );

endmodule

### hdl/slru_front.sv
// ---------------------------------------------------------------------------
// Set-associative LRU tag lookup: front end
// Accepts addresses, derives set index and tag, pushes them to the queue.
// ---------------------------------------------------------------------------
module slru_front import slru_pkg::*; #(
    parameter int SETS      = SETS_DEFAULT,
    parameter int ADDR_BITS = ADDR_BITS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfg_t                 cfg,
    input  logic                 clearing,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [ADDR_BITS-1:0] s_address,
    input  logic                 q_full,
    output logic                 q_push,
    output qent_t                q_data
);

    localparam int EXT_W    = (ADDR_BITS > TAG_W) ? ADDR_BITS : TAG_W;
    localparam int RECIP_SH = 20;
    localparam int RECIP_W  = RECIP_SH + 1;
    localparam longint RECIP_L = ((longint'(1) << RECIP_SH) + longint'(SETS) - 1)
                                 / longint'(SETS);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
    localparam int PROD_W = SET_W + RECIP_W;
    localparam int QD_W   = SET_W + 17;

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_MOD  = 4'b0010,
        F_FIX  = 4'b0100,
        F_PUSH = 4'b1000
    } fstate_t;

    fstate_t          state_reg, state_next;
    logic [SET_W-1:0] set_reg, set_next;
    logic [TAG_W-1:0] tag_reg, tag_next;
    logic [SET_W-1:0] quot_reg, quot_next;

    logic [3:0]       ib;
    logic [SET_W:0]   imask;
    logic [ADDR_BITS-1:0] shifted;
    logic [SET_W-1:0] set_raw;
    logic [5:0]       tag_shift;
    logic [EXT_W-1:0] tag_ext;
    logic [PROD_W-1:0] prod;
    logic [QD_W-1:0]  qd;

    assign ib        = (cfg.index_bits > 4'(MAX_INDEX_BITS)) ? 4'(MAX_INDEX_BITS)
                                                             : cfg.index_bits;
    assign imask     = (11'd1 << ib) - 11'd1;
    assign shifted   = s_address >> cfg.offset_bits;
    assign set_raw   = shifted[SET_W-1:0] & imask[SET_W-1:0];
    assign tag_shift = {1'b0, cfg.offset_bits} + {2'b00, ib};
    assign tag_ext   = EXT_W'(s_address) >> tag_shift;

    // remainder by SETS: reciprocal multiply for the quotient, then subtract
    assign prod = PROD_W'(set_reg) * PROD_W'(RECIP);
    assign qd   = QD_W'(quot_reg) * QD_W'(SETS);

    assign s_ready = (state_reg == F_IDLE) && !clearing;
    assign q_push  = (state_reg == F_PUSH) && !q_full;
    assign q_data  = '{set_index: set_reg, tag: tag_reg};

    always_comb begin
        state_next = state_reg;
        set_next   = set_reg;
        tag_next   = tag_reg;
        quot_next  = quot_reg;
        case (state_reg)
            F_IDLE: begin
                if (s_valid && s_ready) begin
                    set_next = set_raw;
                    tag_next = tag_ext[TAG_W-1:0];
                    if (32'(set_raw) >= 32'(SETS)) begin
                        state_next = F_MOD;
                    end else begin
                        state_next = F_PUSH;
                    end
                end
            end
            F_MOD: begin
                quot_next  = prod[RECIP_SH +: SET_W];
                state_next = F_FIX;
            end
            F_FIX: begin
                set_next   = set_reg - qd[SET_W-1:0];
                state_next = F_PUSH;
            end
            F_PUSH: begin
                if (!q_full) begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
        set_reg  <= set_next;
        tag_reg  <= tag_next;
        quot_reg <= quot_next;
    end

endmodule

### hdl/slru_queue.sv
// ---------------------------------------------------------------------------
// Set-associative LRU tag lookup: decoupling queue
// Two-entry FIFO between front end and back end.
// ---------------------------------------------------------------------------
`include "set_assoc_lru_tag_lookup_defines.svh"

module slru_queue import slru_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  qent_t push_data,
    output logic  full,
    input  logic  pop,
    output qent_t pop_data,
    output logic  empty
);

    qent_t      mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `SLRU_ASSERT_NOW(a_no_overflow, full, !push, "push into full queue")
    `SLRU_ASSERT_NOW(a_no_underflow, empty, !pop, "pop from empty queue")
    `SLRU_ASSERT_NOW(a_count_range, 1'b1, count_reg != 2'd3, "queue count out of range")

endmodule

### hdl/slru_back.sv
// ---------------------------------------------------------------------------
// Set-associative LRU tag lookup: back end
// Reads a set row, compares tags, updates LRU ranks and writes the row back.
// ---------------------------------------------------------------------------
`include "set_assoc_lru_tag_lookup_defines.svh"

module slru_back import slru_pkg::*; #(
    parameter int SETS = SETS_DEFAULT,
    parameter int WAYS = WAYS_DEFAULT
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  cfg_t             cfg,
    output logic             clearing,
    input  logic             q_empty,
    input  qent_t            q_data,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_hit,
    output logic [SET_W-1:0] m_set_index,
    output logic             m_evicted,
    output logic [TAG_W-1:0] m_evicted_tag,
    output logic [CNT_W-1:0] m_hit_total,
    output logic [CNT_W-1:0] m_access_total
);

    localparam int SW  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int RW  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int WIW = RW;
    localparam int VCW = $clog2(WAYS + 1);

    typedef enum logic [2:0] {
        B_CLEAR = 3'b001,
        B_IDLE  = 3'b010,
        B_CALC  = 3'b100
    } bstate_t;

    logic [WAYS-1:0]              v_mem    [SETS];
    logic [WAYS-1:0][RW-1:0]      rank_mem [SETS];
    logic [WAYS-1:0][TAG_W-1:0]   tag_mem  [SETS];

    bstate_t                    state_reg, state_next;
    logic [SW-1:0]              clr_reg, clr_next;
    logic [SET_W-1:0]           cur_set_reg;
    logic [TAG_W-1:0]           cur_tag_reg;
    logic [WAYS-1:0]            rd_v_reg;
    logic [WAYS-1:0][RW-1:0]    rd_rank_reg;
    logic [WAYS-1:0][TAG_W-1:0] rd_tag_reg;

    logic                       out_valid_reg;
    logic                       out_hit_reg;
    logic [SET_W-1:0]           out_set_reg;
    logic                       out_evicted_reg;
    logic [TAG_W-1:0]           out_ev_tag_reg;
    logic [CNT_W-1:0]           hit_cnt_reg, hit_cnt_next;
    logic [CNT_W-1:0]           acc_cnt_reg, acc_cnt_next;

    logic                       commit;
    logic                       hit, have_victim, free_found, evict;
    logic [WIW-1:0]             hw, victim, free_w, target;
    logic [RW-1:0]              hit_rank, max_rank;
    logic [VCW-1:0]             vcnt, limit;
    logic [WAYS-1:0]            new_v;
    logic [WAYS-1:0][RW-1:0]    new_rank;
    logic [WAYS-1:0][TAG_W-1:0] new_tag;
    logic [TAG_W-1:0]           ev_tag;

    logic                       wr_en;
    logic [SW-1:0]              wr_addr;
    logic [WAYS-1:0]            wr_v;

    assign clearing = (state_reg == B_CLEAR);
    assign q_pop    = (state_reg == B_IDLE) && !q_empty;
    assign commit   = (state_reg == B_CALC) && (!out_valid_reg || m_ready);

    always_comb begin
        hit         = 1'b0;
        hw          = '0;
        hit_rank    = '0;
        vcnt        = '0;
        have_victim = 1'b0;
        victim      = '0;
        max_rank    = '0;
        free_found  = 1'b0;
        free_w      = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (rd_v_reg[w]) begin
                vcnt = vcnt + VCW'(1);
                if (!hit && (rd_tag_reg[w] == cur_tag_reg)) begin
                    hit      = 1'b1;
                    hw       = WIW'(w);
                    hit_rank = rd_rank_reg[w];
                end
                if (!have_victim || (rd_rank_reg[w] > max_rank)) begin
                    have_victim = 1'b1;
                    victim      = WIW'(w);
                    max_rank    = rd_rank_reg[w];
                end
            end else if (!free_found) begin
                free_found = 1'b1;
                free_w     = WIW'(w);
            end
        end

        if (cfg.ways_in_use == 4'd0) begin
            limit = VCW'(1);
        end else if (32'(cfg.ways_in_use) > 32'(WAYS)) begin
            limit = VCW'(WAYS);
        end else begin
            limit = VCW'(cfg.ways_in_use);
        end

        evict  = !hit && (vcnt >= limit);
        target = hit ? hw : (evict ? victim : free_w);
        ev_tag = evict ? rd_tag_reg[victim] : '0;

        new_tag = rd_tag_reg;
        for (int w = 0; w < WAYS; w++) begin
            new_v[w]    = rd_v_reg[w];
            new_rank[w] = rd_rank_reg[w];
            if (hit) begin
                if (rd_v_reg[w] && (rd_rank_reg[w] < hit_rank)) begin
                    new_rank[w] = rd_rank_reg[w] + RW'(1);
                end
            end else begin
                if (evict && (victim == WIW'(w))) begin
                    new_v[w] = 1'b0;
                end
                if (new_v[w]) begin
                    new_rank[w] = rd_rank_reg[w] + RW'(1);
                end
            end
        end
        new_v[target]    = 1'b1;
        new_rank[target] = '0;
        new_tag[target]  = cur_tag_reg;
    end

    assign wr_en   = clearing || commit;
    assign wr_addr = clearing ? clr_reg : SW'(cur_set_reg);
    assign wr_v    = clearing ? '0 : new_v;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            v_mem[wr_addr]    <= wr_v;
            rank_mem[wr_addr] <= new_rank;
            tag_mem[wr_addr]  <= new_tag;
        end
        if (q_pop) begin
            rd_v_reg    <= v_mem[SW'(q_data.set_index)];
            rd_rank_reg <= rank_mem[SW'(q_data.set_index)];
            rd_tag_reg  <= tag_mem[SW'(q_data.set_index)];
            cur_set_reg <= q_data.set_index;
            cur_tag_reg <= q_data.tag;
        end
    end

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        hit_cnt_next = hit_cnt_reg;
        acc_cnt_next = acc_cnt_reg;
        case (state_reg)
            B_CLEAR: begin
                clr_next = clr_reg + SW'(1);
                if (32'(clr_reg) == 32'(SETS - 1)) begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE: begin
                if (q_pop) begin
                    state_next = B_CALC;
                end
            end
            B_CALC: begin
                if (commit) begin
                    state_next   = B_IDLE;
                    acc_cnt_next = acc_cnt_reg + CNT_W'(1);
                    if (hit) begin
                        hit_cnt_next = hit_cnt_reg + CNT_W'(1);
                    end
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_CLEAR;
            clr_reg       <= '0;
            hit_cnt_reg   <= '0;
            acc_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            hit_cnt_reg <= hit_cnt_next;
            acc_cnt_reg <= acc_cnt_next;
            if (commit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (commit) begin
            out_hit_reg     <= hit;
            out_set_reg     <= cur_set_reg;
            out_evicted_reg <= evict;
            out_ev_tag_reg  <= ev_tag;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_hit          = out_hit_reg;
    assign m_set_index    = out_set_reg;
    assign m_evicted      = out_evicted_reg;
    assign m_evicted_tag  = out_ev_tag_reg;
    assign m_hit_total    = hit_cnt_reg;
    assign m_access_total = acc_cnt_reg;

    `SLRU_ASSERT_NOW(a_hit_no_evict, m_valid, !(m_hit && m_evicted), "hit with eviction")
    `SLRU_ASSERT_NEXT(a_commit_shows, commit, m_valid, "committed result not shown")
    `SLRU_ASSERT_NOW(a_clear_no_pop, clearing, !q_pop, "item taken during clear")

endmodule
